[src/triplet_to_compressed_column_unit_macros.svh]
// assertion macros for the triplet to compressed-column unit
// used by the top level only, no other dependencies
`ifndef TRIPLET_TO_COMPRESSED_COLUMN_UNIT_MACROS_SVH
`define TRIPLET_TO_COMPRESSED_COLUMN_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define T2CC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition holds at every clock edge out of reset
`define T2CC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

`endif

[src/t2cc_pkg.sv]
// shared types and constants for the triplet to compressed-column unit
// no dependencies
`default_nettype none

package t2cc_pkg;

    localparam int OP_W  = 3;
    localparam int COL_W = 11;
    localparam int ROW_W = 16;
    localparam int VAL_W = 32;
    localparam int POS_W = 17;
    localparam int ST_W  = 2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    localparam logic [COL_W-1:0] NUM_COLUMNS_RST = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_COUNT  = 3'd1,
        OP_PREFIX = 3'd2,
        OP_PLACE  = 3'd3,
        OP_READ   = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC,
        S_PFX,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

[src/t2cc_in_if.sv]
// input channel carrying one triplet command item
// depends on t2cc_pkg
`default_nettype none

interface t2cc_in_if;
    logic                          valid;
    logic                          ready;
    logic [t2cc_pkg::OP_W-1:0]     opcode;
    logic [t2cc_pkg::COL_W-1:0]    column_index;
    logic [t2cc_pkg::ROW_W-1:0]    row_index;
    logic [t2cc_pkg::VAL_W-1:0]    entry_value;

    modport source (output valid, output opcode, output column_index,
                    output row_index, output entry_value, input ready);
    modport sink   (input valid, input opcode, input column_index,
                    input row_index, input entry_value, output ready);
endinterface

`default_nettype wire

[src/t2cc_out_if.sv]
// output channel carrying one result item
// depends on t2cc_pkg
`default_nettype none

interface t2cc_out_if;
    logic                          valid;
    logic                          ready;
    logic [t2cc_pkg::POS_W-1:0]    position;
    logic [t2cc_pkg::ROW_W-1:0]    row_out;
    logic [t2cc_pkg::VAL_W-1:0]    value_out;
    logic [t2cc_pkg::POS_W-1:0]    total_entries;
    logic [t2cc_pkg::ST_W-1:0]     status;

    modport source (output valid, output position, output row_out, output value_out,
                    output total_entries, output status, input ready);
    modport sink   (input valid, input position, input row_out, input value_out,
                    input total_entries, input status, output ready);
endinterface

`default_nettype wire

[src/triplet_to_compressed_column_unit.sv]
// triplet to compressed-column conversion unit (counting sort)
// depends on t2cc_pkg, t2cc_in_if, t2cc_out_if, t2cc_ram and the macros header
//
// usage:
//   i_in_item  carries command items: clear, count, prefix, place, read pointer
//   o_out_item returns exactly one result item per command, in order
//   i_cfg_we / i_cfg_data write num_columns while the unit is idle
// steps:
//   count and place go through accept, memory read and read-modify-write
//   of the count ram, result register load; read pointer reads the start
//   ram instead; an out-of-range command or an unused opcode skips memory
//   prefix writes each running sum to both rams, then stores the total
//   clear zeroes every count ram entry, one entry per cycle
// reset:
//   after reset the count ram is zeroed in a full sweep; no item is
//   accepted during that pass, config writes are taken as usual
// stalls:
//   the result sits in an output register; the next item is accepted while
//   it waits, and the unit holds its following result until the slot frees
`default_nettype none

`include "triplet_to_compressed_column_unit_macros.svh"

module triplet_to_compressed_column_unit #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_NZ   = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [t2cc_pkg::COL_W-1:0]    i_cfg_data,
    t2cc_in_if.sink                            i_in_item,
    t2cc_out_if.source                         o_out_item
);

    localparam int CW   = $clog2(MAX_NZ + 1);
    localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SAW  = $clog2(MAX_COLS + 1);
    localparam int NW   = $clog2(MAX_COLS + 1);
    localparam int CMPW = (NW > t2cc_pkg::COL_W) ? NW : t2cc_pkg::COL_W;

    localparam logic [CW-1:0]   MAXNZ_C   = CW'(MAX_NZ);
    localparam logic [CW:0]     MAXNZ_X   = (CW + 1)'(MAX_NZ);
    localparam logic [CMPW-1:0] MAXCOLS_C = CMPW'(MAX_COLS);
    localparam logic [NW-1:0]   LAST_COL  = NW'(MAX_COLS - 1);

    t2cc_pkg::t_state r_state, n_state;

    logic [t2cc_pkg::COL_W-1:0] r_num_columns, n_num_columns;
    logic [NW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_pk, n_pk;
    logic                       r_pv, n_pv;
    logic [CW-1:0]              r_sum, n_sum;
    logic                       r_psat, n_psat;
    logic [CW-1:0]              r_total, n_total;
    logic                       r_clr, n_clr;

    logic [t2cc_pkg::OP_W-1:0]  r_op, n_op;
    logic [CMPW-1:0]            r_col, n_col;
    logic [t2cc_pkg::ROW_W-1:0] r_row, n_row;
    logic [t2cc_pkg::VAL_W-1:0] r_val, n_val;

    logic [CW-1:0]              r_res_pos, n_res_pos;
    logic [t2cc_pkg::ROW_W-1:0] r_res_row, n_res_row;
    logic [t2cc_pkg::VAL_W-1:0] r_res_val, n_res_val;
    logic [t2cc_pkg::ST_W-1:0]  r_res_st, n_res_st;

    logic                       r_out_valid, n_out_valid;
    logic [t2cc_pkg::POS_W-1:0] r_out_pos, n_out_pos;
    logic [t2cc_pkg::ROW_W-1:0] r_out_row, n_out_row;
    logic [t2cc_pkg::VAL_W-1:0] r_out_val, n_out_val;
    logic [t2cc_pkg::POS_W-1:0] r_out_total, n_out_total;
    logic [t2cc_pkg::ST_W-1:0]  r_out_st, n_out_st;

    logic            cnt_we, cnt_re;
    logic [AW-1:0]   cnt_waddr, cnt_raddr;
    logic [CW-1:0]   cnt_wdata, cnt_rdata;
    logic            st_we, st_re;
    logic [SAW-1:0]  st_waddr, st_raddr;
    logic [CW-1:0]   st_wdata, st_rdata;

    logic [CMPW-1:0] ncols, cfg_ext, col_ext;
    logic            in_ready;

    assign cfg_ext = CMPW'(r_num_columns);
    assign ncols   = (cfg_ext > MAXCOLS_C) ? MAXCOLS_C : cfg_ext;
    assign col_ext = CMPW'(i_in_item.column_index);

    t2cc_ram #(
        .DEPTH (MAX_COLS),
        .WIDTH (CW),
        .AW    (AW)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    t2cc_ram #(
        .DEPTH (MAX_COLS + 1),
        .WIDTH (CW),
        .AW    (SAW)
    ) u_starts (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    always_comb begin
        logic [CW:0] psum;
        psum          = {1'b0, r_sum} + {1'b0, cnt_rdata};
        n_state       = r_state;
        n_num_columns = i_cfg_we ? i_cfg_data : r_num_columns;
        n_idx         = r_idx;
        n_pk          = r_pk;
        n_pv          = r_pv;
        n_sum         = r_sum;
        n_psat        = r_psat;
        n_total       = r_total;
        n_clr         = r_clr;
        n_op          = r_op;
        n_col         = r_col;
        n_row         = r_row;
        n_val         = r_val;
        n_res_pos     = r_res_pos;
        n_res_row     = r_res_row;
        n_res_val     = r_res_val;
        n_res_st      = r_res_st;
        n_out_valid   = r_out_valid && !o_out_item.ready;
        n_out_pos     = r_out_pos;
        n_out_row     = r_out_row;
        n_out_val     = r_out_val;
        n_out_total   = r_out_total;
        n_out_st      = r_out_st;
        cnt_we        = 1'b0;
        cnt_waddr     = r_idx[AW-1:0];
        cnt_wdata     = '0;
        cnt_re        = 1'b0;
        cnt_raddr     = col_ext[AW-1:0];
        st_we         = 1'b0;
        st_waddr      = SAW'(r_pk);
        st_wdata      = r_sum;
        st_re         = 1'b0;
        st_raddr      = col_ext[SAW-1:0];
        in_ready      = 1'b0;

        case (r_state)
            t2cc_pkg::S_SWEEP: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_idx[AW-1:0];
                cnt_wdata = '0;
                if (r_idx == LAST_COL) begin
                    n_idx   = '0;
                    n_clr   = 1'b0;
                    n_state = r_clr ? t2cc_pkg::S_EMIT : t2cc_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            t2cc_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_item.valid) begin
                    n_op      = i_in_item.opcode;
                    n_col     = col_ext;
                    n_row     = i_in_item.row_index;
                    n_val     = i_in_item.entry_value;
                    n_res_pos = '0;
                    n_res_row = '0;
                    n_res_val = '0;
                    n_res_st  = t2cc_pkg::ST_OK;
                    n_state   = t2cc_pkg::S_EMIT;
                    case (i_in_item.opcode)
                        t2cc_pkg::OP_CLEAR: begin
                            n_total = '0;
                            n_clr   = 1'b1;
                            n_idx   = '0;
                            n_state = t2cc_pkg::S_SWEEP;
                        end
                        t2cc_pkg::OP_COUNT, t2cc_pkg::OP_PLACE: begin
                            if (col_ext >= ncols) begin
                                n_res_st = t2cc_pkg::ST_RANGE;
                            end else begin
                                cnt_re  = 1'b1;
                                n_state = t2cc_pkg::S_EXEC;
                            end
                        end
                        t2cc_pkg::OP_PREFIX: begin
                            n_idx   = '0;
                            n_sum   = '0;
                            n_psat  = 1'b0;
                            n_pv    = 1'b0;
                            n_state = t2cc_pkg::S_PFX;
                        end
                        t2cc_pkg::OP_READ: begin
                            if (col_ext > ncols) begin
                                n_res_st = t2cc_pkg::ST_RANGE;
                            end else begin
                                st_re   = 1'b1;
                                n_state = t2cc_pkg::S_EXEC;
                            end
                        end
                        default: begin
                            n_res_st = t2cc_pkg::ST_OK;
                        end
                    endcase
                end
            end
            t2cc_pkg::S_EXEC: begin
                cnt_waddr = r_col[AW-1:0];
                cnt_wdata = cnt_rdata + 1'b1;
                case (r_op)
                    t2cc_pkg::OP_COUNT: begin
                        if (cnt_rdata >= MAXNZ_C) begin
                            n_res_pos = cnt_rdata;
                            n_res_st  = t2cc_pkg::ST_SAT;
                        end else begin
                            cnt_we    = 1'b1;
                            n_res_pos = cnt_rdata + 1'b1;
                        end
                    end
                    t2cc_pkg::OP_PLACE: begin
                        n_res_row = r_row;
                        n_res_val = r_val;
                        if (cnt_rdata >= MAXNZ_C) begin
                            n_res_pos = MAXNZ_C;
                            n_res_st  = t2cc_pkg::ST_SAT;
                        end else begin
                            cnt_we    = 1'b1;
                            n_res_pos = cnt_rdata;
                        end
                    end
                    t2cc_pkg::OP_READ: begin
                        n_res_pos = st_rdata;
                    end
                    default: begin
                        n_res_pos = '0;
                    end
                endcase
                n_state = t2cc_pkg::S_EMIT;
            end
            t2cc_pkg::S_PFX: begin
                if (r_pv) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_pk;
                    cnt_wdata = r_sum;
                    st_we     = 1'b1;
                    st_waddr  = SAW'(r_pk);
                    st_wdata  = r_sum;
                    if (psum > MAXNZ_X) begin
                        n_sum  = MAXNZ_C;
                        n_psat = 1'b1;
                    end else begin
                        n_sum = psum[CW-1:0];
                    end
                end
                if (CMPW'(r_idx) < ncols) begin
                    cnt_re    = 1'b1;
                    cnt_raddr = r_idx[AW-1:0];
                    n_pk      = r_idx[AW-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_pv      = 1'b1;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        st_we     = 1'b1;
                        st_waddr  = ncols[SAW-1:0];
                        st_wdata  = r_sum;
                        n_total   = r_sum;
                        n_res_pos = '0;
                        n_res_st  = r_psat ? t2cc_pkg::ST_SAT : t2cc_pkg::ST_OK;
                        n_state   = t2cc_pkg::S_EMIT;
                    end
                end
            end
            t2cc_pkg::S_EMIT: begin
                if (!r_out_valid || o_out_item.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = t2cc_pkg::POS_W'(r_res_pos);
                    n_out_row   = r_res_row;
                    n_out_val   = r_res_val;
                    n_out_total = t2cc_pkg::POS_W'(r_total);
                    n_out_st    = r_res_st;
                    n_state     = t2cc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = t2cc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= t2cc_pkg::S_SWEEP;
            r_num_columns <= t2cc_pkg::NUM_COLUMNS_RST;
            r_idx         <= '0;
            r_pv          <= 1'b0;
            r_psat        <= 1'b0;
            r_total       <= '0;
            r_clr         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_num_columns <= n_num_columns;
            r_idx         <= n_idx;
            r_pv          <= n_pv;
            r_psat        <= n_psat;
            r_total       <= n_total;
            r_clr         <= n_clr;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pk        <= n_pk;
        r_sum       <= n_sum;
        r_op        <= n_op;
        r_col       <= n_col;
        r_row       <= n_row;
        r_val       <= n_val;
        r_res_pos   <= n_res_pos;
        r_res_row   <= n_res_row;
        r_res_val   <= n_res_val;
        r_res_st    <= n_res_st;
        r_out_pos   <= n_out_pos;
        r_out_row   <= n_out_row;
        r_out_val   <= n_out_val;
        r_out_total <= n_out_total;
        r_out_st    <= n_out_st;
    end

    assign i_in_item.ready        = in_ready;
    assign o_out_item.valid       = r_out_valid;
    assign o_out_item.position    = r_out_pos;
    assign o_out_item.row_out     = r_out_row;
    assign o_out_item.value_out   = r_out_val;
    assign o_out_item.total_entries = r_out_total;
    assign o_out_item.status      = r_out_st;

    `T2CC_ASSERT_IMP(a_range_zero, i_clk, i_rst_n, r_out_valid && (r_out_st == t2cc_pkg::ST_RANGE), (r_out_pos == '0) && (r_out_row == '0) && (r_out_val == '0))
    `T2CC_ASSERT_ALWAYS(a_total_bound, i_clk, i_rst_n, r_total <= MAXNZ_C)
    `T2CC_ASSERT_IMP(a_pv_in_prefix, i_clk, i_rst_n, r_pv, r_state == t2cc_pkg::S_PFX)

endmodule

`default_nettype wire

[src/t2cc_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`default_nettype none

module t2cc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 17,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
